>>> hdl/rdb_pkg.sv
// Shared types, constants and helpers for the ring deque buffer.
`timescale 1ns / 1ps

package rdb_pkg;

   localparam int POS_W          = 5;
   localparam int KIND_W         = 4;
   localparam int VAL_W          = 32;
   localparam int STAT_W         = 3;
   localparam int MAX_CELLS      = (1 << POS_W) - 1;
   localparam int CAP_RESET      = 16;
   localparam int DEF_DEPTH      = 16;
   localparam int DEF_DATA_WIDTH = 32;

   typedef enum logic [KIND_W-1:0] {
      K_PUSH_BACK  = 4'd0,
      K_PUSH_FRONT = 4'd1,
      K_POP_BACK   = 4'd2,
      K_POP_FRONT  = 4'd3,
      K_READ       = 4'd4,
      K_WRITE      = 4'd5,
      K_INSERT     = 4'd6,
      K_ERASE      = 4'd7,
      K_ROTATE     = 4'd8,
      K_RESIZE     = 4'd9,
      K_CLEAR      = 4'd10
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      S_OK    = 3'd0,
      S_EMPTY = 3'd1,
      S_FULL  = 3'd2,
      S_INDEX = 3'd3,
      S_RANGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      C_HOLD,
      C_WRITE,
      C_LOAD,
      C_SHIFT,
      C_COMMIT,
      C_INSERT,
      C_FILL
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INS,
      ST_SHIFT,
      ST_COMMIT,
      ST_DONE
   } state_type;

   // Command broadcast to every cell. Positions are logical, addr is physical.
   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   head;
      logic [POS_W-1:0]   cap;
      logic [POS_W-1:0]   lo;
      logic [POS_W-1:0]   hi;
      logic [POS_W-1:0]   addr;
   } cell_cmd_type;

   // Ring addition, valid when a + b stays below twice cap.
   function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b,
                                                 input logic [POS_W-1:0] cap);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, cap}) begin
         sum = sum - {1'b0, cap};
      end
      return sum[POS_W-1:0];
   endfunction

endpackage

>>> hdl/rdb_req_if.sv
// Request channel interface: operation beats into the buffer.
`timescale 1ns / 1ps

interface rdb_req_if import rdb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [POS_W-1:0]  position;
   logic [POS_W-1:0]  position_end;
   logic [VAL_W-1:0]  value;

   modport source (output valid, kind, position, position_end, value, input ready);
   modport sink   (input valid, kind, position, position_end, value, output ready);
endinterface

>>> hdl/rdb_rsp_if.sv
// Response channel interface: one result beat per operation.
`timescale 1ns / 1ps

interface rdb_rsp_if import rdb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VAL_W-1:0]  read_data;
   logic [STAT_W-1:0] status;
   logic [POS_W-1:0]  occupancy;

   modport source (output valid, read_data, status, occupancy, input ready);
   modport sink   (input valid, read_data, status, occupancy, output ready);
endinterface

>>> hdl/rdb_cell.sv
// One storage cell of the ring: a slot word and a travel word for range moves.
`timescale 1ns / 1ps

module rdb_cell import rdb_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] data,
   input  logic [DATA_WIDTH-1:0] prev_slot,
   input  logic [DATA_WIDTH-1:0] next_slot,
   input  logic [DATA_WIDTH-1:0] first_slot,
   input  logic [DATA_WIDTH-1:0] next_travel,
   input  logic [DATA_WIDTH-1:0] first_travel,
   output logic [DATA_WIDTH-1:0] slot_q,
   output logic [DATA_WIDTH-1:0] travel_q
);

   localparam logic [POS_W:0] K = (POS_W+1)'(IDX);

   logic [DATA_WIDTH-1:0] slot_ff, slot_in;
   logic [DATA_WIDTH-1:0] travel_ff, travel_in;
   logic [POS_W:0]        head_ext, cap_ext;
   logic [POS_W-1:0]      lg;
   logic                  in_ring, is_last, in_lo_hi;

   assign head_ext = {1'b0, cmd.head};
   assign cap_ext  = {1'b0, cmd.cap};
   assign in_ring  = K < cap_ext;
   assign is_last  = K == (cap_ext - (POS_W+1)'(1));
   assign in_lo_hi = (lg >= cmd.lo) && (lg < cmd.hi);

   // Logical index of this cell relative to the current head.
   always_comb begin
      if (K >= head_ext) begin
         lg = POS_W'(K - head_ext);
      end else begin
         lg = POS_W'(K + cap_ext - head_ext);
      end
   end

   always_comb begin
      slot_in   = slot_ff;
      travel_in = travel_ff;
      unique case (cmd.op)
         C_HOLD: begin
         end
         C_WRITE: begin
            if (K[POS_W-1:0] == cmd.addr) slot_in = data;
         end
         C_LOAD: begin
            travel_in = is_last ? first_slot : next_slot;
         end
         C_SHIFT: begin
            travel_in = is_last ? first_travel : next_travel;
         end
         C_COMMIT: begin
            if (in_ring && in_lo_hi) slot_in = travel_ff;
         end
         C_INSERT: begin
            if (in_ring) begin
               if (lg == cmd.lo) begin
                  slot_in = data;
               end else if ((lg > cmd.lo) && (lg <= cmd.hi)) begin
                  slot_in = prev_slot;
               end
            end
         end
         C_FILL: begin
            if (in_ring && in_lo_hi) slot_in = data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      travel_ff <= travel_in;
   end

   assign slot_q   = slot_ff;
   assign travel_q = travel_ff;

endmodule

>>> hdl/rdb_ctrl.sv
// Sequencer: pointers, occupancy, operation decode and the result register.
`timescale 1ns / 1ps

module rdb_ctrl import rdb_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int NUM_CELLS  = DEF_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [POS_W-1:0]      csr_wr_data,
   rdb_req_if.sink               req,
   rdb_rsp_if.source             rsp,
   input  logic [DATA_WIDTH-1:0] rd_word,
   output cell_cmd_type          cmd,
   output logic [DATA_WIDTH-1:0] cmd_data,
   output logic [DATA_WIDTH-1:0] wrap_word
);

   localparam logic [POS_W-1:0] CELLS   = POS_W'(NUM_CELLS);
   localparam logic [POS_W-1:0] CAP_RST = POS_W'(NUM_CELLS < CAP_RESET ? NUM_CELLS : CAP_RESET);
   localparam logic [POS_W-1:0] ONE     = POS_W'(1);

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      cap_ff, cap_in;
   logic [POS_W-1:0]      head_ff, head_in;
   logic [POS_W-1:0]      cnt_ff, cnt_in;
   kind_type              kind_ff;
   logic [POS_W-1:0]      pos_ff, pend_ff;
   logic [DATA_WIDTH-1:0] val_ff, word_ff;
   logic [POS_W-1:0]      lo_ff, lo_in, hi_ff, hi_in, left_ff, left_in;
   status_type            res_stat_ff, res_stat_in;
   logic [VAL_W-1:0]      res_data_ff, res_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]      rsp_data_ff;
   status_type            rsp_stat_ff;
   logic [POS_W-1:0]      rsp_occ_ff;

   logic                  rsp_free, accept, load_rsp;
   logic [POS_W-1:0]      tail, head_inc, head_dec, pos_slot, span;
   logic                  is_empty, is_full, idx_bad, ins_bad, rng_bad, size_bad;
   logic                  ins_go, ers_go;

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && rsp_free);
   assign accept    = req.valid && req.ready;
   assign load_rsp  = (state_ff == ST_DONE) && rsp_free;

   // Ring arithmetic and checks on the latched operation.
   assign tail     = wrap_add(head_ff, cnt_ff, cap_ff);
   assign head_inc = wrap_add(head_ff, ONE, cap_ff);
   assign head_dec = (head_ff == '0) ? (cap_ff - ONE) : (head_ff - ONE);
   assign pos_slot = wrap_add(head_ff, pos_ff, cap_ff);
   assign span     = pend_ff - pos_ff;
   assign is_empty = cnt_ff == '0;
   assign is_full  = cnt_ff == cap_ff;
   assign idx_bad  = pos_ff >= cnt_ff;
   assign ins_bad  = pos_ff > cnt_ff;
   assign rng_bad  = (pend_ff > cnt_ff) || (pos_ff >= pend_ff);
   assign size_bad = pos_ff > cap_ff;
   assign ins_go   = (kind_ff == K_INSERT) && !ins_bad && !is_full;
   assign ers_go   = (kind_ff == K_ERASE) && !rng_bad;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ins_go) begin
               state_in = ST_INS;
            end else if (ers_go) begin
               state_in = (span == ONE) ? ST_COMMIT : ST_SHIFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INS: begin
            state_in = ST_DONE;
         end
         ST_SHIFT: begin
            if (left_ff == ONE) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls per state.
   always_comb begin
      cap_in      = cap_ff;
      head_in     = head_ff;
      cnt_in      = cnt_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      left_in     = left_ff;
      res_stat_in = res_stat_ff;
      res_data_in = res_data_ff;
      cmd.op      = C_HOLD;
      cmd.head    = head_ff;
      cmd.cap     = cap_ff;
      cmd.lo      = lo_ff;
      cmd.hi      = hi_ff;
      cmd.addr    = pos_slot;

      unique case (state_ff)
         ST_EXEC: begin
            res_stat_in = S_OK;
            res_data_in = '0;
            unique case (kind_ff)
               K_PUSH_BACK: begin
                  cmd.op   = C_WRITE;
                  cmd.addr = tail;
                  if (is_full) head_in = head_inc;
                  else         cnt_in  = cnt_ff + ONE;
               end
               K_PUSH_FRONT: begin
                  cmd.op   = C_WRITE;
                  cmd.addr = head_dec;
                  head_in  = head_dec;
                  if (!is_full) cnt_in = cnt_ff + ONE;
               end
               K_POP_BACK: begin
                  if (is_empty) res_stat_in = S_EMPTY;
                  else          cnt_in      = cnt_ff - ONE;
               end
               K_POP_FRONT: begin
                  if (is_empty) begin
                     res_stat_in = S_EMPTY;
                  end else begin
                     head_in = head_inc;
                     cnt_in  = cnt_ff - ONE;
                  end
               end
               K_READ: begin
                  if (idx_bad) res_stat_in = S_INDEX;
                  else         res_data_in = VAL_W'(rd_word);
               end
               K_WRITE: begin
                  if (idx_bad) res_stat_in = S_INDEX;
                  else         cmd.op      = C_WRITE;
               end
               K_INSERT: begin
                  // The last ring slot is fetched now for the wrap into cell zero.
                  cmd.addr = cap_ff - ONE;
                  lo_in    = pos_ff;
                  hi_in    = cnt_ff;
                  if (ins_bad)      res_stat_in = S_INDEX;
                  else if (is_full) res_stat_in = S_FULL;
               end
               K_ERASE: begin
                  if (rng_bad) begin
                     res_stat_in = S_RANGE;
                  end else begin
                     cmd.op  = C_LOAD;
                     lo_in   = pos_ff;
                     hi_in   = cnt_ff - span;
                     left_in = span - ONE;
                  end
               end
               K_ROTATE: begin
                  if (idx_bad) res_stat_in = S_INDEX;
                  else         head_in     = pos_slot;
               end
               K_RESIZE: begin
                  if (size_bad) begin
                     res_stat_in = S_INDEX;
                  end else begin
                     cmd.op = C_FILL;
                     cmd.lo = cnt_ff;
                     cmd.hi = pos_ff;
                     cnt_in = pos_ff;
                  end
               end
               K_CLEAR: begin
                  head_in = '0;
                  cnt_in  = '0;
               end
               default: begin
               end
            endcase
         end
         ST_INS: begin
            cmd.op = C_INSERT;
            cnt_in = cnt_ff + ONE;
         end
         ST_SHIFT: begin
            cmd.op  = C_SHIFT;
            left_in = left_ff - ONE;
         end
         ST_COMMIT: begin
            cmd.op = C_COMMIT;
            cnt_in = hi_ff;
         end
         default: begin
         end
      endcase

      if (csr_wr_en) begin
         if (csr_wr_data == '0)        cap_in = ONE;
         else if (csr_wr_data > CELLS) cap_in = CELLS;
         else                          cap_in = csr_wr_data;
         head_in = '0;
         cnt_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)       rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RST;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req.kind);
         pos_ff  <= req.position;
         pend_ff <= req.position_end;
         val_ff  <= DATA_WIDTH'(req.value);
      end
      if (state_ff == ST_EXEC) word_ff <= rd_word;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      left_ff     <= left_in;
      res_stat_ff <= res_stat_in;
      res_data_ff <= res_data_in;
      if (load_rsp) begin
         rsp_data_ff <= res_data_ff;
         rsp_stat_ff <= res_stat_ff;
         rsp_occ_ff  <= cnt_ff;
      end
   end

   assign cmd_data      = val_ff;
   assign wrap_word     = word_ff;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
   assign rsp.status    = rsp_stat_ff;
   assign rsp.occupancy = rsp_occ_ff;

endmodule

>>> hdl/ring_deque_buffer.sv
// Top level of the ring deque buffer: sequencer plus a ring of storage cells.
`timescale 1ns / 1ps
//
// A double-ended ring over a row of storage cells. Each request beat on req_ch
// carries one operation (push or pop at either end, indexed read or write,
// insert, range erase, rotate, resize, clear) and produces exactly one beat on
// rsp_ch with the read data, a status code and the occupancy after the
// operation. csr_wr_en/csr_wr_data set the capacity; a write empties the ring
// and must only happen while no operation is in flight.
//
// Operations run one at a time. A simple operation executes and completes, an
// insert adds a step that moves the tail up by one slot, and an erase walks the
// erased span down the cell chain one cell per cycle and then commits it. The
// response sits in its own register, so the next request is accepted while a
// response waits; when rsp_ch stalls the operation after it completes internally
// and then holds until the response register drains.
//
// Reset (synchronous) zeroes the slot word of every cell, the pointers and the
// occupancy, and sets the capacity to 16 slots (or the cell count, if smaller).

module ring_deque_buffer import rdb_pkg::*; #(
   parameter int DEPTH      = DEF_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [POS_W-1:0] csr_wr_data,
   rdb_req_if.sink          req_ch,
   rdb_rsp_if.source        rsp_ch
);

   // Capacity is a 5-bit register, so cells beyond its reach are never built.
   localparam int NUM_CELLS = (DEPTH < MAX_CELLS) ? DEPTH : MAX_CELLS;

   cell_cmd_type          cmd;
   logic [DATA_WIDTH-1:0] cmd_data;
   logic [DATA_WIDTH-1:0] wrap_word;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [DATA_WIDTH-1:0] slot_q   [NUM_CELLS];
   logic [DATA_WIDTH-1:0] travel_q [NUM_CELLS];

   rdb_ctrl #(
      .DATA_WIDTH (DATA_WIDTH),
      .NUM_CELLS  (NUM_CELLS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .rd_word     (rd_word),
      .cmd         (cmd),
      .cmd_data    (cmd_data),
      .wrap_word   (wrap_word)
   );

   // Each cell hands its word to the neighbor below it during an erase and
   // takes the word from the cell below it during an insert. The ring closes
   // at the capacity: cell zero's lower neighbor comes from the sequencer,
   // which fetches and registers the last ring slot before the insert step.
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_slot, next_slot, next_travel;

      if (k == 0) begin : g_first
         assign prev_slot = wrap_word;
      end else begin : g_mid
         assign prev_slot = slot_q[k-1];
      end

      if (k == NUM_CELLS - 1) begin : g_end
         assign next_slot   = slot_q[0];
         assign next_travel = travel_q[0];
      end else begin : g_inner
         assign next_slot   = slot_q[k+1];
         assign next_travel = travel_q[k+1];
      end

      rdb_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX        (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .data         (cmd_data),
         .prev_slot    (prev_slot),
         .next_slot    (next_slot),
         .first_slot   (slot_q[0]),
         .next_travel  (next_travel),
         .first_travel (travel_q[0]),
         .slot_q       (slot_q[k]),
         .travel_q     (travel_q[k])
      );
   end

   // Single read port over the cells, addressed by the sequencer.
   always_comb begin
      rd_word = '0;
      for (int k = 0; k < NUM_CELLS; k++) begin
         if (cmd.addr == POS_W'(k)) rd_word = rd_word | slot_q[k];
      end
   end

endmodule
